>>> rtl/msk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_pkg
// Shared constants and types for the min tracking stack: request and status
// codes, default sizes and the shift command that drives the row of cells.
// ----------------------------------------------------------------------------
package msk_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int COUNT_W_DEF    = $clog2(DEPTH_DEF + 1);

	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_TOP  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_MIN  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SIZE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

	// one command to the whole row of cells per cycle
	typedef struct packed {
		logic push;
		logic pop;
	} shift_t;

endpackage

>>> rtl/msk_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_req_if
// Request channel: valid/ready handshake with request code and push value.
// ----------------------------------------------------------------------------
interface msk_req_if #(
	parameter int DATA_WIDTH = msk_pkg::DATA_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic        [msk_pkg::REQ_W-1:0]  req_type;
	logic signed [DATA_WIDTH-1:0]      push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

>>> rtl/msk_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_rsp_if
// Response channel: valid/ready handshake with result, status and count.
// ----------------------------------------------------------------------------
interface msk_rsp_if #(
	parameter int DATA_WIDTH = msk_pkg::DATA_WIDTH_DEF,
	parameter int COUNT_W    = msk_pkg::COUNT_W_DEF
);
	logic                                valid;
	logic                                ready;
	logic signed [DATA_WIDTH-1:0]        result_value;
	logic        [msk_pkg::STATUS_W-1:0] status;
	logic        [COUNT_W-1:0]           entry_count;

	modport source (output valid, output result_value, output status,
		output entry_count, input ready);
	modport sink   (input valid, input result_value, input status,
		input entry_count, output ready);
endinterface

>>> rtl/msk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_cell
// One stack slot. On push it takes the entry of its upper neighbor, on pop
// the entry of its lower neighbor, otherwise it holds.
// ----------------------------------------------------------------------------
module msk_cell #(
	parameter int ENTRY_W = msk_pkg::DATA_WIDTH_DEF + 2
) (
	input  logic                 clk,
	input  msk_pkg::shift_t      shift,
	input  logic [ENTRY_W-1:0]   upper,
	input  logic [ENTRY_W-1:0]   lower,
	output logic [ENTRY_W-1:0]   entry_q
);

	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= upper;
		end else if (shift.pop) begin
			entry_q <= lower;
		end
	end

endmodule

>>> rtl/min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack
// Signed LIFO stack that reports its running minimum with a single minimum
// register and encoded entries, built as a shifting row of cells.
// ----------------------------------------------------------------------------
// Every request (push, pop, top, min, size) gives exactly one response. A
// request is taken on its handshake and its response is registered, so the
// block sustains one request per clock while the response side keeps up; the
// figure is set by the single output register, since the top of stack always
// sits in the first cell and needs no memory read. Entries are DATA_WIDTH+2
// bits: a push below the minimum stores 2*value - min and the value becomes
// the minimum; pop undoes it with 2*min - entry. Pop, top or min on an empty
// stack answer status underflow, a push onto a full stack answers overflow
// and changes nothing. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
	parameter int DEPTH      = msk_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = msk_pkg::DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	msk_req_if.sink    req,
	msk_rsp_if.source  rsp
);

	localparam int ENTRY_W = DATA_WIDTH + 2;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

	logic [ENTRY_W-1:0] cell_q [DEPTH];

	logic [COUNT_W-1:0]           count_q;
	logic signed [DATA_WIDTH-1:0] min_q;

	logic                                rsp_valid_q;
	logic signed [DATA_WIDTH-1:0]        result_q;
	logic        [msk_pkg::STATUS_W-1:0] status_q;
	logic        [COUNT_W-1:0]           rsp_count_q;

	logic accept;
	logic empty;
	logic full;

	logic signed [ENTRY_W-1:0] val_ext;
	logic signed [ENTRY_W-1:0] min_ext;
	logic signed [ENTRY_W-1:0] top_ext;
	logic signed [ENTRY_W-1:0] enc_below;
	logic signed [ENTRY_W-1:0] min_restore;
	logic signed [ENTRY_W-1:0] push_entry;

	msk_pkg::shift_t                     shift;
	logic                                min_we;
	logic signed [DATA_WIDTH-1:0]        min_d;
	logic        [COUNT_W-1:0]           count_d;
	logic signed [DATA_WIDTH-1:0]        result_d;
	logic        [msk_pkg::STATUS_W-1:0] status_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_COUNT);

	assign val_ext = {{2{req.push_value[DATA_WIDTH-1]}}, req.push_value};
	assign min_ext = {{2{min_q[DATA_WIDTH-1]}}, min_q};
	assign top_ext = cell_q[0];

	// 2*value - min and 2*min - entry, both exact in the entry width
	assign enc_below   = {val_ext[ENTRY_W-2:0], 1'b0} - min_ext;
	assign min_restore = {min_ext[ENTRY_W-2:0], 1'b0} - top_ext;

	always_comb begin
		shift      = '0;
		min_we     = 1'b0;
		min_d      = min_q;
		count_d    = count_q;
		result_d   = '0;
		status_d   = msk_pkg::ST_OK;
		push_entry = val_ext;
		case (req.req_type)
			msk_pkg::REQ_PUSH: begin
				if (full) begin
					status_d = msk_pkg::ST_OVER;
				end else begin
					shift.push = 1'b1;
					count_d    = count_q + 1'b1;
					if (empty) begin
						min_we = 1'b1;
						min_d  = req.push_value;
					end else if (val_ext < min_ext) begin
						push_entry = enc_below;
						min_we     = 1'b1;
						min_d      = req.push_value;
					end
				end
			end
			msk_pkg::REQ_POP, msk_pkg::REQ_TOP: begin
				if (empty) begin
					status_d = msk_pkg::ST_UNDER;
				end else begin
					if (top_ext >= min_ext) begin
						result_d = top_ext[DATA_WIDTH-1:0];
					end else begin
						// encoded entry: the value was the minimum itself
						result_d = min_q;
						if (req.req_type == msk_pkg::REQ_POP) begin
							min_we = 1'b1;
							min_d  = min_restore[DATA_WIDTH-1:0];
						end
					end
					if (req.req_type == msk_pkg::REQ_POP) begin
						shift.pop = 1'b1;
						count_d   = count_q - 1'b1;
					end
				end
			end
			msk_pkg::REQ_MIN: begin
				if (empty) begin
					status_d = msk_pkg::ST_UNDER;
				end else begin
					result_d = min_q;
				end
			end
			default: begin
				// size and unused codes change nothing
			end
		endcase
		if (!accept) begin
			shift  = '0;
			min_we = 1'b0;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [ENTRY_W-1:0] upper;
			logic [ENTRY_W-1:0] lower;
			if (gi == 0) begin : g_first
				assign upper = push_entry;
			end else begin : g_mid_up
				assign upper = cell_q[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign lower = cell_q[gi];
			end else begin : g_mid_dn
				assign lower = cell_q[gi+1];
			end
			msk_cell #(
				.ENTRY_W (ENTRY_W)
			) u_cell (
				.clk     (clk),
				.shift   (shift),
				.upper   (upper),
				.lower   (lower),
				.entry_q (cell_q[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			min_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (min_we) begin
				min_q <= min_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q    <= result_d;
			status_q    <= status_d;
			rsp_count_q <= count_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = result_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count beyond depth");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == msk_pkg::REQ_POP && !empty
		|=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not remove one entry");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == msk_pkg::REQ_PUSH && full
		|=> rsp.status == msk_pkg::ST_OVER && count_q == $past(count_q))
		else $error("push onto full stack not refused");

	a_min_report: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == msk_pkg::REQ_MIN && !empty
		|=> rsp.valid && rsp.result_value == $past(min_q))
		else $error("min request returned wrong value");

endmodule

>>> test/min_tracking_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_checker
// Watches the request and response channels of the min tracking stack, keeps
// its own copy of the stack and the running minimum, predicts the response to
// every accepted request and compares it field by field, in order.
// ----------------------------------------------------------------------------
module min_tracking_stack_checker #(
	parameter int DEPTH = msk_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	msk_req_if   req_mon,
	msk_rsp_if   rsp_mon,
	output int   mismatches,
	output int   replies_pending,
	output int   replies_checked,
	output int   overflows_seen,
	output int   underflows_seen,
	output int   encoded_pushes
);

	localparam int VALUE_W = msk_pkg::DATA_WIDTH_DEF;
	localparam int COUNT_W = msk_pkg::COUNT_W_DEF;

	typedef struct packed {
		logic signed [VALUE_W-1:0]           result_value;
		logic        [msk_pkg::STATUS_W-1:0] status;
		logic        [COUNT_W-1:0]           entry_count;
	} stack_reply_t;

	// entries are kept wide: an encoded entry needs two bits beyond the value
	longint       stored_entries [DEPTH];
	int           stack_depth;
	longint       running_min;
	stack_reply_t reply_queue [$];

	function automatic stack_reply_t apply_request(input logic [msk_pkg::REQ_W-1:0] code,
		input logic signed [VALUE_W-1:0] value);
		stack_reply_t reply;
		longint       wide_value;
		longint       top_entry;
		reply        = '0;
		reply.status = msk_pkg::ST_OK;
		wide_value   = value;
		case (code)
			msk_pkg::REQ_PUSH: begin
				if (stack_depth == DEPTH) begin
					reply.status = msk_pkg::ST_OVER;
					overflows_seen++;
				end else if (stack_depth == 0) begin
					stored_entries[0] = wide_value;
					running_min       = wide_value;
					stack_depth       = 1;
				end else begin
					if (wide_value >= running_min) begin
						stored_entries[stack_depth] = wide_value;
					end else begin
						// entry lands below the new minimum, marking it as encoded
						stored_entries[stack_depth] = 2 * wide_value - running_min;
						running_min = wide_value;
						encoded_pushes++;
					end
					stack_depth++;
				end
			end
			msk_pkg::REQ_POP, msk_pkg::REQ_TOP, msk_pkg::REQ_MIN: begin
				if (stack_depth == 0) begin
					reply.status = msk_pkg::ST_UNDER;
					underflows_seen++;
				end else begin
					top_entry = stored_entries[stack_depth-1];
					if (code == msk_pkg::REQ_MIN) begin
						reply.result_value = running_min[VALUE_W-1:0];
					end else if (top_entry >= running_min) begin
						reply.result_value = top_entry[VALUE_W-1:0];
						if (code == msk_pkg::REQ_POP) stack_depth--;
					end else begin
						reply.result_value = running_min[VALUE_W-1:0];
						if (code == msk_pkg::REQ_POP) begin
							running_min = 2 * running_min - top_entry;
							stack_depth--;
						end
					end
				end
			end
			default: ;
		endcase
		reply.entry_count = COUNT_W'(stack_depth);
		return reply;
	endfunction

	always @(posedge clk) begin
		stack_reply_t want;
		stack_reply_t got;
		if (!arst_n) begin
			mismatches      = 0;
			replies_pending = 0;
			replies_checked = 0;
			overflows_seen  = 0;
			underflows_seen = 0;
			encoded_pushes  = 0;
			stack_depth     = 0;
			running_min     = 0;
			reply_queue.delete();
		end else begin
			if (req_mon.valid && req_mon.ready)
				reply_queue.push_back(apply_request(req_mon.req_type,
					req_mon.push_value));
			if (rsp_mon.valid && rsp_mon.ready) begin
				got.result_value = rsp_mon.result_value;
				got.status       = rsp_mon.status;
				got.entry_count  = rsp_mon.entry_count;
				if (reply_queue.size() == 0) begin
					$error("response with no request waiting: %s %0d %0d %0d",
						"result_value status entry_count",
						$signed(got.result_value), got.status, got.entry_count);
					mismatches++;
				end else begin
					want = reply_queue.pop_front();
					replies_checked++;
					if (got.result_value !== want.result_value) begin
						$error("result_value: expected %0d, got %0d",
							$signed(want.result_value), $signed(got.result_value));
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						mismatches++;
					end
				end
			end
			replies_pending = reply_queue.size();
		end
	end

endmodule

>>> test/min_tracking_stack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_test
// Drives push, pop, top, min, size and unused request codes into the min
// tracking stack: a directed opening on the value extremes and empty-stack
// cases, random mixes under changing idle and stall patterns, then a fill to
// overflow under every idle pattern and a short drain. A checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module min_tracking_stack_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int FILL_PUSHES    = msk_pkg::DEPTH_DEF + 6;
	localparam int FILL_CHUNK     = FILL_PUSHES / 4 + 1;

	localparam logic signed [31:0] VALUE_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] VALUE_MIN = 32'sh80000000;

	// request codes the block must ignore
	localparam logic [msk_pkg::REQ_W-1:0] REQ_RSVD_A = 3'd5;
	localparam logic [msk_pkg::REQ_W-1:0] REQ_RSVD_B = 3'd6;
	localparam logic [msk_pkg::REQ_W-1:0] REQ_RSVD_C = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	int     sender_idle_pct;
	int     receiver_stall_pct;
	int     requests_sent;
	int     quiet_cycles;
	longint falling_value;

	int mismatches;
	int replies_pending;
	int replies_checked;
	int overflows_seen;
	int underflows_seen;
	int encoded_pushes;

	msk_req_if req_ch ();
	msk_rsp_if rsp_ch ();

	min_tracking_stack uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	min_tracking_stack_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_mon         (req_ch),
		.rsp_mon         (rsp_ch),
		.mismatches      (mismatches),
		.replies_pending (replies_pending),
		.replies_checked (replies_checked),
		.overflows_seen  (overflows_seen),
		.underflows_seen (underflows_seen),
		.encoded_pushes  (encoded_pushes)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// ends the run when no transfer happens on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) ||
			(rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
			1: begin
				sender_idle_pct    = 61;
				receiver_stall_pct = 0;
			end
			2: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 61;
			end
			default: begin
				sender_idle_pct    = 16;
				receiver_stall_pct = 16;
			end
		endcase
	endtask

	// called and returns at a falling edge
	task automatic send_request(input logic [msk_pkg::REQ_W-1:0] code,
		input logic signed [31:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= code;
		req_ch.push_value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	// mixes full-range, near-zero, extreme and steadily falling values
	function automatic logic signed [31:0] pick_value();
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 20) return $urandom;
		if (kind < 45) return $signed(32'($urandom_range(40))) - 32'sd20;
		if (kind < 55) begin
			case ($urandom_range(3))
				0: return VALUE_MAX;
				1: return VALUE_MIN;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		falling_value = falling_value - longint'($urandom_range(1, 1000));
		if (falling_value < longint'(VALUE_MIN)) falling_value = longint'($signed($urandom));
		return falling_value[31:0];
	endfunction

	task automatic send_random_request(input int push_pct);
		int unsigned pick;
		pick = $urandom_range(99);
		if ($urandom_range(99) < push_pct) begin
			send_request(msk_pkg::REQ_PUSH, pick_value());
		end else if (pick < 45) begin
			send_request(msk_pkg::REQ_POP, $urandom);
		end else if (pick < 65) begin
			send_request(msk_pkg::REQ_TOP, $urandom);
		end else if (pick < 82) begin
			send_request(msk_pkg::REQ_MIN, $urandom);
		end else if (pick < 95) begin
			send_request(msk_pkg::REQ_SIZE, $urandom);
		end else begin
			case ($urandom_range(2))
				0: send_request(REQ_RSVD_A, $urandom);
				1: send_request(REQ_RSVD_B, $urandom);
				default: send_request(REQ_RSVD_C, $urandom);
			endcase
		end
	endtask

	initial begin
		int push_pct;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = msk_pkg::REQ_SIZE;
		req_ch.push_value  = '0;
		requests_sent      = 0;
		falling_value      = 0;
		set_idling(0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty stack: underflows, size and ignored codes
		send_request(msk_pkg::REQ_POP, VALUE_MIN);
		send_request(msk_pkg::REQ_TOP, VALUE_MAX);
		send_request(msk_pkg::REQ_MIN, $urandom);
		send_request(msk_pkg::REQ_SIZE, $urandom);
		send_request(REQ_RSVD_A, $urandom);
		send_request(REQ_RSVD_B, $urandom);
		send_request(REQ_RSVD_C, $urandom);
		// widest encoding: most negative value below the largest minimum
		send_request(msk_pkg::REQ_PUSH, VALUE_MAX);
		send_request(msk_pkg::REQ_PUSH, VALUE_MIN);
		send_request(msk_pkg::REQ_PUSH, VALUE_MIN);
		send_request(msk_pkg::REQ_PUSH, 32'sd0);
		send_request(msk_pkg::REQ_TOP, $urandom);
		send_request(msk_pkg::REQ_MIN, $urandom);
		send_request(msk_pkg::REQ_SIZE, $urandom);
		send_request(REQ_RSVD_C, $urandom);
		send_request(msk_pkg::REQ_POP, $urandom);
		send_request(msk_pkg::REQ_POP, $urandom);
		send_request(msk_pkg::REQ_TOP, $urandom);
		send_request(msk_pkg::REQ_POP, $urandom);
		send_request(msk_pkg::REQ_MIN, $urandom);
		send_request(msk_pkg::REQ_POP, $urandom);
		// the minimum left over from the emptied stack must be replaced
		send_request(msk_pkg::REQ_MIN, $urandom);
		send_request(msk_pkg::REQ_PUSH, 32'sd5);
		send_request(msk_pkg::REQ_MIN, $urandom);
		send_request(msk_pkg::REQ_POP, $urandom);

		push_pct = 50;
		for (int phase = 0; phase < 4; phase++) begin
			set_idling(phase);
			for (int i = 0; i < 40; i++) begin
				if (i % 20 == 0) push_pct = $urandom_range(30, 70);
				send_random_request(push_pct);
			end
		end

		// fill past the top under every idle pattern, then pop a few back
		for (int chunk = 0; chunk < 4; chunk++) begin
			set_idling(chunk);
			repeat (FILL_CHUNK) send_request(msk_pkg::REQ_PUSH, pick_value());
		end
		send_request(msk_pkg::REQ_MIN, $urandom);
		send_request(msk_pkg::REQ_TOP, $urandom);
		send_request(msk_pkg::REQ_SIZE, $urandom);
		set_idling(3);
		repeat (24) send_request(msk_pkg::REQ_POP, $urandom);
		send_request(msk_pkg::REQ_TOP, $urandom);
		send_request(msk_pkg::REQ_MIN, $urandom);
		req_ch.valid <= 1'b0;

		while (replies_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("covered %0d requests and %0d checked responses",
			requests_sent, replies_checked);
		$display("pushes encoded below the minimum: %0d, %s %0d, %s %0d",
			encoded_pushes, "full-stack refusals:", overflows_seen,
			"empty-stack underflows:", underflows_seen);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
